[rtl/core/gamepad_input_conditioner_unit_assert.svh]
// Assertion macros for the gamepad input conditioner.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef GAMEPAD_INPUT_CONDITIONER_UNIT_ASSERT_SVH
`define GAMEPAD_INPUT_CONDITIONER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GICU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GICU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/gicu_pkg.sv]
// Types and constants for the gamepad input conditioner.
// No dependencies.
package gicu_pkg;

	localparam int TimeW = 32;
	localparam int LevelW = 8;
	localparam int SampleW = 12;
	localparam int Q15W = 15;
	localparam int AxisW = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;

	localparam logic [Q15W-1:0] Q15Max = 15'd32767;

	localparam logic [TimeW-1:0] DebounceRst = 32'd20000;
	localparam logic [Q15W-1:0] DeadZoneRst = 15'd3277;
	localparam logic [SampleW-1:0] CentreRst = 12'd2048;
	localparam logic [SampleW-1:0] MinimumRst = 12'd0;
	localparam logic [SampleW-1:0] MaximumRst = 12'd4095;

	typedef struct packed {
		logic [TimeW-1:0] time_us;
		logic [LevelW-1:0] button_levels;
		logic [SampleW-1:0] x_sample;
		logic [SampleW-1:0] y_sample;
	} in_t;

	typedef struct packed {
		logic [LevelW-1:0] held_buttons;
		logic [LevelW-1:0] pressed_edges;
		logic [LevelW-1:0] released_edges;
		logic signed [AxisW-1:0] x_axis;
		logic signed [AxisW-1:0] y_axis;
	} out_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_DEBOUNCE_US,
		CFG_DEAD_ZONE,
		CFG_X_CENTRE,
		CFG_X_MINIMUM,
		CFG_X_MAXIMUM,
		CFG_Y_CENTRE,
		CFG_Y_MINIMUM,
		CFG_Y_MAXIMUM
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BTN,
		ST_AX_SETUP,
		ST_DIV,
		ST_AX_DONE,
		ST_EMIT
	} state_t;

endpackage

[rtl/core/gamepad_input_conditioner_unit.sv]
// Gamepad input conditioner: time-based button debounce and joystick Q15 scaling.
// Depends on gicu_pkg and gamepad_input_conditioner_unit_assert.svh.
// One item in flight: a new frame is accepted only once the previous result has been loaded for output.
// The sequencer steps through every button in turn, then each axis that is neither empty nor saturated
// through the shared 15-step restoring divider, and waits in emit while a waiting result is not yet taken.
// arst_n clears the sequencer, the button state and loads the register defaults.
`include "gamepad_input_conditioner_unit_assert.svh"

module gamepad_input_conditioner_unit #(
	parameter int BUTTONS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  gicu_pkg::in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output gicu_pkg::out_t out_data,
	input  logic cfg_wen,
	input  logic [gicu_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [gicu_pkg::CfgDataW-1:0] cfg_data
);

	localparam int BtnIdxW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

	// Configuration registers
	logic [gicu_pkg::TimeW-1:0] debounce_q;
	logic [gicu_pkg::Q15W-1:0] dead_zone_q;
	logic [gicu_pkg::SampleW-1:0] x_centre_q, x_minimum_q, x_maximum_q;
	logic [gicu_pkg::SampleW-1:0] y_centre_q, y_minimum_q, y_maximum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= gicu_pkg::DebounceRst;
			dead_zone_q <= gicu_pkg::DeadZoneRst;
			x_centre_q <= gicu_pkg::CentreRst;
			x_minimum_q <= gicu_pkg::MinimumRst;
			x_maximum_q <= gicu_pkg::MaximumRst;
			y_centre_q <= gicu_pkg::CentreRst;
			y_minimum_q <= gicu_pkg::MinimumRst;
			y_maximum_q <= gicu_pkg::MaximumRst;
		end else if (cfg_wen) begin
			unique case (gicu_pkg::cfg_idx_t'(cfg_index))
				gicu_pkg::CFG_DEBOUNCE_US: debounce_q <= cfg_data;
				gicu_pkg::CFG_DEAD_ZONE:   dead_zone_q <= cfg_data[gicu_pkg::Q15W-1:0];
				gicu_pkg::CFG_X_CENTRE:    x_centre_q <= cfg_data[gicu_pkg::SampleW-1:0];
				gicu_pkg::CFG_X_MINIMUM:   x_minimum_q <= cfg_data[gicu_pkg::SampleW-1:0];
				gicu_pkg::CFG_X_MAXIMUM:   x_maximum_q <= cfg_data[gicu_pkg::SampleW-1:0];
				gicu_pkg::CFG_Y_CENTRE:    y_centre_q <= cfg_data[gicu_pkg::SampleW-1:0];
				gicu_pkg::CFG_Y_MINIMUM:   y_minimum_q <= cfg_data[gicu_pkg::SampleW-1:0];
				gicu_pkg::CFG_Y_MAXIMUM:   y_maximum_q <= cfg_data[gicu_pkg::SampleW-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and datapath registers
	gicu_pkg::state_t state_q, state_d;
	logic [gicu_pkg::TimeW-1:0] time_q;
	logic [gicu_pkg::LevelW-1:0] levels_q;
	logic [gicu_pkg::SampleW-1:0] xs_q, ys_q;
	logic [BtnIdxW-1:0] btn_idx_q;
	logic ax_q;
	logic neg_q;
	logic [gicu_pkg::SampleW-1:0] rem_q, range_q;
	logic [gicu_pkg::Q15W-1:0] num_lo_q, quo_q;
	logic [3:0] cnt_q;
	logic signed [gicu_pkg::AxisW-1:0] x_axis_q, y_axis_q;
	logic out_valid_q;
	gicu_pkg::out_t out_q;

	logic [BUTTONS-1:0] last_level_q, stable_level_q, previous_level_q;
	logic [gicu_pkg::TimeW-1:0] change_time_q [BUTTONS];

	logic in_fire, btn_last, emit_go;
	assign in_ready = (state_q == gicu_pkg::ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign btn_last = (btn_idx_q == BtnIdxW'(BUTTONS - 1));
	assign emit_go = !out_valid_q || out_ready;

	// Buttons above the input width always read released
	logic [BUTTONS-1:0] lvl_vec;
	for (genvar g = 0; g < BUTTONS; g++) begin : g_lvl
		if (g < gicu_pkg::LevelW) begin : g_in
			assign lvl_vec[g] = levels_q[g];
		end else begin : g_zero
			assign lvl_vec[g] = 1'b0;
		end
	end

	logic cur_lvl;
	logic [gicu_pkg::TimeW-1:0] elapsed;
	assign cur_lvl = lvl_vec[btn_idx_q];
	assign elapsed = time_q - change_time_q[btn_idx_q];

	// Axis setup: pick the side of the centre and its range
	logic [gicu_pkg::SampleW-1:0] smp, ctr, amin, amax, diff, rng;
	logic pos, empty, sat;
	logic [gicu_pkg::SampleW+gicu_pkg::Q15W-1:0] num;
	always_comb begin
		smp = ax_q ? ys_q : xs_q;
		ctr = ax_q ? y_centre_q : x_centre_q;
		amin = ax_q ? y_minimum_q : x_minimum_q;
		amax = ax_q ? y_maximum_q : x_maximum_q;
		pos = (smp >= ctr);
		empty = pos ? (amax <= ctr) : (ctr <= amin);
		diff = pos ? (smp - ctr) : (ctr - smp);
		rng = pos ? (amax - ctr) : (ctr - amin);
		// a deflection at or past the range end scales to full scale or more
		sat = (diff >= rng);
		// diff * 32767
		num = {diff, {gicu_pkg::Q15W{1'b0}}} - {{gicu_pkg::Q15W{1'b0}}, diff};
	end

	// Divider step
	logic [gicu_pkg::SampleW:0] trial;
	logic fits;
	assign trial = {rem_q, num_lo_q[gicu_pkg::Q15W-1]};
	assign fits = (trial >= {1'b0, range_q});

	// Final axis value
	logic signed [gicu_pkg::AxisW-1:0] ax_val;
	always_comb begin
		if (quo_q < dead_zone_q) begin
			ax_val = '0;
		end else if (neg_q) begin
			ax_val = gicu_pkg::AxisW'(0) - {1'b0, quo_q};
		end else begin
			ax_val = {1'b0, quo_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gicu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gicu_pkg::ST_IDLE: begin
				if (in_fire) state_d = gicu_pkg::ST_BTN;
			end
			gicu_pkg::ST_BTN: begin
				if (btn_last) state_d = gicu_pkg::ST_AX_SETUP;
			end
			gicu_pkg::ST_AX_SETUP: begin
				state_d = (empty || sat) ? gicu_pkg::ST_AX_DONE : gicu_pkg::ST_DIV;
			end
			gicu_pkg::ST_DIV: begin
				if (cnt_q == 4'd1) state_d = gicu_pkg::ST_AX_DONE;
			end
			gicu_pkg::ST_AX_DONE: begin
				state_d = ax_q ? gicu_pkg::ST_EMIT : gicu_pkg::ST_AX_SETUP;
			end
			gicu_pkg::ST_EMIT: begin
				if (emit_go) state_d = gicu_pkg::ST_IDLE;
			end
			default: state_d = gicu_pkg::ST_IDLE;
		endcase
	end

	// Button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= '0;
			stable_level_q <= '0;
			previous_level_q <= '0;
			for (int i = 0; i < BUTTONS; i++) change_time_q[i] <= '0;
		end else if (state_q == gicu_pkg::ST_BTN) begin
			if (cur_lvl != last_level_q[btn_idx_q]) begin
				last_level_q[btn_idx_q] <= cur_lvl;
				change_time_q[btn_idx_q] <= time_q;
			end else if (elapsed >= debounce_q) begin
				previous_level_q[btn_idx_q] <= stable_level_q[btn_idx_q];
				stable_level_q[btn_idx_q] <= cur_lvl;
			end
		end
	end

	// Control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_idx_q <= '0;
			ax_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				gicu_pkg::ST_IDLE: begin
					btn_idx_q <= '0;
					ax_q <= 1'b0;
				end
				gicu_pkg::ST_BTN: begin
					if (!btn_last) btn_idx_q <= btn_idx_q + 1'b1;
				end
				gicu_pkg::ST_AX_SETUP: cnt_q <= 4'(gicu_pkg::Q15W);
				gicu_pkg::ST_DIV: cnt_q <= cnt_q - 1'b1;
				gicu_pkg::ST_AX_DONE: ax_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Output valid: load a beat from emit, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == gicu_pkg::ST_EMIT && emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Button outputs sampled when the beat is loaded
	logic [gicu_pkg::LevelW-1:0] held_w, prev_w;
	for (genvar g = 0; g < gicu_pkg::LevelW; g++) begin : g_out
		if (g < BUTTONS) begin : g_btn
			assign held_w[g] = stable_level_q[g];
			assign prev_w[g] = previous_level_q[g];
		end else begin : g_none
			assign held_w[g] = 1'b0;
			assign prev_w[g] = 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			time_q <= in_data.time_us;
			levels_q <= in_data.button_levels;
			xs_q <= in_data.x_sample;
			ys_q <= in_data.y_sample;
		end
		unique case (state_q)
			gicu_pkg::ST_AX_SETUP: begin
				neg_q <= !pos;
				range_q <= rng;
				rem_q <= num[gicu_pkg::SampleW+gicu_pkg::Q15W-1:gicu_pkg::Q15W];
				num_lo_q <= num[gicu_pkg::Q15W-1:0];
				if (empty) begin
					quo_q <= '0;
				end else if (sat) begin
					quo_q <= gicu_pkg::Q15Max;
				end else begin
					quo_q <= '0;
				end
			end
			gicu_pkg::ST_DIV: begin
				// shift one numerator bit into the remainder, subtract if it fits
				rem_q <= fits ? gicu_pkg::SampleW'(trial - {1'b0, range_q})
				              : trial[gicu_pkg::SampleW-1:0];
				num_lo_q <= {num_lo_q[gicu_pkg::Q15W-2:0], 1'b0};
				quo_q <= {quo_q[gicu_pkg::Q15W-2:0], fits};
			end
			gicu_pkg::ST_AX_DONE: begin
				if (!ax_q) x_axis_q <= ax_val;
				else y_axis_q <= ax_val;
			end
			gicu_pkg::ST_EMIT: begin
				// hold the waiting beat until it is taken
				if (emit_go) begin
					out_q.held_buttons <= held_w;
					out_q.pressed_edges <= held_w & ~prev_w;
					out_q.released_edges <= ~held_w & prev_w;
					out_q.x_axis <= x_axis_q;
					out_q.y_axis <= y_axis_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`GICU_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready, "accepted beat did not block input")
	`GICU_ASSERT_NOW(a_beat_from_emit, $rose(out_valid_q), $past(state_q == gicu_pkg::ST_EMIT),
		"output beat loaded outside emit")
	`GICU_ASSERT_NOW(a_rem_below_range, state_q == gicu_pkg::ST_DIV, rem_q < range_q,
		"divider remainder not below divisor")

endmodule

[sim/gicu_frame_checker.sv]
`timescale 1ns / 1ps
// Frame checker for the gamepad input conditioner: predicts each result beat
// from the accepted frame beats and register writes, then compares in order.
// Depends on gicu_pkg.
module gicu_frame_checker #(
	parameter int BUTTONS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  gicu_pkg::in_t in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  gicu_pkg::out_t out_data,
	input  logic cfg_wen,
	input  logic [gicu_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [gicu_pkg::CfgDataW-1:0] cfg_data,
	output int mismatch_count,
	output int frames_pending
);
	import gicu_pkg::*;

	// Register copy; axis arrays hold X at 0 and Y at 1.
	logic [TimeW-1:0] debounce_time;
	logic [Q15W-1:0] dead_zone_q15;
	logic [SampleW-1:0] centre_cfg [2];
	logic [SampleW-1:0] minimum_cfg [2];
	logic [SampleW-1:0] maximum_cfg [2];

	// Per-button debounce state.
	logic last_lvl [BUTTONS];
	logic stable_lvl [BUTTONS];
	logic prior_lvl [BUTTONS];
	logic [TimeW-1:0] change_stamp [BUTTONS];

	out_t expected_frames [$];
	out_t want;

	function automatic logic [AxisW-1:0] scale_to_q15(input logic [SampleW-1:0] sample,
			input logic [SampleW-1:0] centre, input logic [SampleW-1:0] minimum,
			input logic [SampleW-1:0] maximum);
		logic [31:0] diff;
		logic [31:0] span;
		logic [31:0] mag;
		logic neg;
		if (sample >= centre) begin
			if (maximum <= centre)
				return '0;
			span = maximum - centre;
			diff = sample - centre;
			neg = 1'b0;
		end else begin
			if (centre <= minimum)
				return '0;
			span = centre - minimum;
			diff = centre - sample;
			neg = 1'b1;
		end
		mag = (diff * 32'd32767) / span;
		// Dead zone applies before the clamp.
		if (mag < dead_zone_q15)
			return '0;
		if (mag > Q15Max)
			mag = Q15Max;
		return neg ? AxisW'(~mag + 32'd1) : AxisW'(mag);
	endfunction

	function automatic out_t condition_frame(input in_t f);
		out_t r;
		logic lvl;
		r = '0;
		for (int i = 0; i < BUTTONS; i++) begin
			lvl = (i < LevelW) ? f.button_levels[i] : 1'b0;
			if (lvl != last_lvl[i]) begin
				last_lvl[i] = lvl;
				change_stamp[i] = f.time_us;
			end else if (TimeW'(f.time_us - change_stamp[i]) >= debounce_time) begin
				prior_lvl[i] = stable_lvl[i];
				stable_lvl[i] = lvl;
			end
			if (i < LevelW) begin
				r.held_buttons[i] = stable_lvl[i];
				r.pressed_edges[i] = stable_lvl[i] && !prior_lvl[i];
				r.released_edges[i] = !stable_lvl[i] && prior_lvl[i];
			end
		end
		r.x_axis = scale_to_q15(f.x_sample, centre_cfg[0], minimum_cfg[0], maximum_cfg[0]);
		r.y_axis = scale_to_q15(f.y_sample, centre_cfg[1], minimum_cfg[1], maximum_cfg[1]);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_time = DebounceRst;
			dead_zone_q15 = DeadZoneRst;
			for (int a = 0; a < 2; a++) begin
				centre_cfg[a] = CentreRst;
				minimum_cfg[a] = MinimumRst;
				maximum_cfg[a] = MaximumRst;
			end
			for (int i = 0; i < BUTTONS; i++) begin
				last_lvl[i] = 1'b0;
				stable_lvl[i] = 1'b0;
				prior_lvl[i] = 1'b0;
				change_stamp[i] = '0;
			end
			expected_frames.delete();
			mismatch_count = 0;
			frames_pending <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					CFG_DEBOUNCE_US: debounce_time = cfg_data[TimeW-1:0];
					CFG_DEAD_ZONE:   dead_zone_q15 = cfg_data[Q15W-1:0];
					CFG_X_CENTRE:    centre_cfg[0] = cfg_data[SampleW-1:0];
					CFG_X_MINIMUM:   minimum_cfg[0] = cfg_data[SampleW-1:0];
					CFG_X_MAXIMUM:   maximum_cfg[0] = cfg_data[SampleW-1:0];
					CFG_Y_CENTRE:    centre_cfg[1] = cfg_data[SampleW-1:0];
					CFG_Y_MINIMUM:   minimum_cfg[1] = cfg_data[SampleW-1:0];
					CFG_Y_MAXIMUM:   maximum_cfg[1] = cfg_data[SampleW-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_frames.push_back(condition_frame(in_data));
			if (out_valid && out_ready) begin
				if (expected_frames.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: unexpected result beat %h", $realtime, out_data);
					mismatch_count++;
				end else begin
					want = expected_frames.pop_front();
					if (want.held_buttons !== out_data.held_buttons
							|| want.pressed_edges !== out_data.pressed_edges
							|| want.released_edges !== out_data.released_edges
							|| want.x_axis !== out_data.x_axis
							|| want.y_axis !== out_data.y_axis) begin
						if (mismatch_count < 10)
							$display("%0t: exp/got held %h/%h pressed %h/%h released %h/%h x %0d/%0d y %0d/%0d",
								$realtime, want.held_buttons, out_data.held_buttons,
								want.pressed_edges, out_data.pressed_edges,
								want.released_edges, out_data.released_edges,
								want.x_axis, out_data.x_axis, want.y_axis, out_data.y_axis);
						mismatch_count++;
					end
				end
			end
			frames_pending <= expected_frames.size();
		end
	end

endmodule

[sim/tb_gamepad_input_conditioner_unit.sv]
`timescale 1ns / 1ps
// Testbench top for gamepad_input_conditioner_unit: drives frames and register
// settings, throttles both channels and gives the verdict. Depends on gicu_pkg,
// gicu_frame_checker and the block itself.
module tb_gamepad_input_conditioner_unit;
	import gicu_pkg::*;

	localparam int BUTTONS = 8;
	localparam int SettingCount = 8;
	localparam int SettingPhases = 8;
	localparam int FramesPerPhase = 60;
	localparam int StallCycles = 400;
	localparam int DrainCycles = BUTTONS + 40;
	localparam int QuietLimit = 3000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;
	logic cfg_wen;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	int mismatch_total;
	int frames_in_flight;
	int send_idle_pct = 30;
	int recv_idle_pct = 49;
	int frames_sent = 0;
	bit hold_request = 1'b0;
	logic [TimeW-1:0] frame_clock;
	logic [LevelW-1:0] level_image;
	logic [CfgDataW-1:0] reg_image [SettingCount];

	gamepad_input_conditioner_unit #(
		.BUTTONS(BUTTONS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	gicu_frame_checker #(
		.BUTTONS(BUTTONS)
	) frame_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_total),
		.frames_pending(frames_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result side: random stalls, or one long hold-off when requested.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (StallCycles) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < QuietLimit) begin
			@(posedge clk);
			if (!arst_n || cfg_wen || (in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	function automatic in_t make_frame(input logic [TimeW-1:0] t, input logic [LevelW-1:0] lv,
			input logic [SampleW-1:0] xs, input logic [SampleW-1:0] ys);
		in_t f;
		f.time_us = t;
		f.button_levels = lv;
		f.x_sample = xs;
		f.y_sample = ys;
		return f;
	endfunction

	// Favor the centre point, its neighbours and the rails.
	function automatic logic [SampleW-1:0] pick_sample(input logic [SampleW-1:0] centre);
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return centre;
			3: return centre - 1'b1;
			4: return centre + 1'b1;
			default: return SampleW'($urandom_range(4095));
		endcase
	endfunction

	// Mostly a steady frame clock with sparse button flips; the rest jumps or runs back.
	function automatic in_t random_frame();
		in_t f;
		int pick;
		logic [LevelW-1:0] flips;
		pick = $urandom_range(99);
		flips = '0;
		if (pick < 85) begin
			frame_clock = frame_clock + $urandom_range(1, 25000);
			for (int b = 0; b < LevelW; b++)
				if ($urandom_range(5) == 0)
					flips[b] = 1'b1;
			level_image = level_image ^ flips;
		end else if (pick < 93) begin
			frame_clock = $urandom();
			level_image = LevelW'($urandom());
		end else begin
			frame_clock = frame_clock - $urandom_range(1, 30000);
		end
		f.time_us = frame_clock;
		f.button_levels = level_image;
		f.x_sample = pick_sample(reg_image[CFG_X_CENTRE][SampleW-1:0]);
		f.y_sample = pick_sample(reg_image[CFG_Y_CENTRE][SampleW-1:0]);
		return f;
	endfunction

	task automatic push_frame(input in_t frame);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= frame;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		frames_sent++;
		if (frames_sent == 100 || frames_sent == 260)
			hold_request = 1'b1;
		if (frames_sent == 170) begin
			send_idle_pct = 49;
			recv_idle_pct = 30;
		end else if (frames_sent == 340) begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	// Drop valid, let every expected beat drain, then let the pipeline settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frames_in_flight != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic choose_settings(input int phase);
		case (phase)
			0: begin
				reg_image[CFG_DEBOUNCE_US] = 32'd0;
				reg_image[CFG_DEAD_ZONE] = 32'd0;
				reg_image[CFG_X_CENTRE] = 32'd2048;
				reg_image[CFG_X_MINIMUM] = 32'd0;
				reg_image[CFG_X_MAXIMUM] = 32'd4095;
				reg_image[CFG_Y_CENTRE] = 32'd0;
				reg_image[CFG_Y_MINIMUM] = 32'd0;
				reg_image[CFG_Y_MAXIMUM] = 32'd4095;
			end
			1: begin
				// Both sides empty on each axis.
				reg_image[CFG_DEBOUNCE_US] = 32'hFFFF_FFFF;
				reg_image[CFG_DEAD_ZONE] = 32'd32767;
				reg_image[CFG_X_CENTRE] = 32'd4095;
				reg_image[CFG_X_MINIMUM] = 32'd4095;
				reg_image[CFG_X_MAXIMUM] = 32'd4095;
				reg_image[CFG_Y_CENTRE] = 32'd2000;
				reg_image[CFG_Y_MINIMUM] = 32'd3000;
				reg_image[CFG_Y_MAXIMUM] = 32'd1000;
			end
			2: begin
				// One-count ranges drive hard into the clamp.
				reg_image[CFG_DEBOUNCE_US] = 32'd1;
				reg_image[CFG_DEAD_ZONE] = 32'd1;
				reg_image[CFG_X_CENTRE] = 32'd1;
				reg_image[CFG_X_MINIMUM] = 32'd0;
				reg_image[CFG_X_MAXIMUM] = 32'd4095;
				reg_image[CFG_Y_CENTRE] = 32'd4094;
				reg_image[CFG_Y_MINIMUM] = 32'd0;
				reg_image[CFG_Y_MAXIMUM] = 32'd4095;
			end
			5: begin
				reg_image[CFG_DEBOUNCE_US] = $urandom_range(0, 60000);
				reg_image[CFG_DEAD_ZONE] = $urandom_range(0, 32767);
				for (int a = CFG_X_CENTRE; a < SettingCount; a++)
					reg_image[a] = $urandom_range(0, 4095);
			end
			7: begin
				reg_image[CFG_DEBOUNCE_US] = DebounceRst;
				reg_image[CFG_DEAD_ZONE] = CfgDataW'(DeadZoneRst);
				reg_image[CFG_X_CENTRE] = CfgDataW'(CentreRst);
				reg_image[CFG_X_MINIMUM] = CfgDataW'(MinimumRst);
				reg_image[CFG_X_MAXIMUM] = CfgDataW'(MaximumRst);
				reg_image[CFG_Y_CENTRE] = CfgDataW'(CentreRst);
				reg_image[CFG_Y_MINIMUM] = CfgDataW'(MinimumRst);
				reg_image[CFG_Y_MAXIMUM] = CfgDataW'(MaximumRst);
			end
			default: begin
				// Realistic stick with some travel lost at the ends.
				reg_image[CFG_DEBOUNCE_US] = $urandom_range(8000, 40000);
				reg_image[CFG_DEAD_ZONE] = $urandom_range(0, 8000);
				for (int a = CFG_X_CENTRE; a <= CFG_Y_CENTRE; a += 3) begin
					reg_image[a] = $urandom_range(1500, 2600);
					reg_image[a + 1] = $urandom_range(0, 600);
					reg_image[a + 2] = $urandom_range(3500, 4095);
				end
			end
		endcase
	endtask

	// Write all registers back to back; bits above each register's width carry junk.
	task automatic write_settings();
		logic [CfgDataW-1:0] junk;
		for (int i = 0; i < SettingCount; i++) begin
			junk = $urandom();
			cfg_wen <= 1'b1;
			cfg_index <= CfgIdxW'(i);
			if (i == CFG_DEBOUNCE_US)
				cfg_data <= reg_image[i];
			else if (i == CFG_DEAD_ZONE)
				cfg_data <= reg_image[i] | (junk & 32'hFFFF_8000);
			else
				cfg_data <= reg_image[i] | (junk & 32'hFFFF_F000);
			@(posedge clk);
		end
		cfg_wen <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		frame_clock = $urandom();
		level_image = '0;
		choose_settings(7);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset settings: full press and release, the
		// dead-zone edges on both sides, and elapsed times that wrap.
		push_frame(make_frame(32'd0, 8'hFF, 12'd0, 12'd4095));
		push_frame(make_frame(32'd10000, 8'hFF, 12'd4095, 12'd0));
		push_frame(make_frame(32'd20000, 8'hFF, 12'd2048, 12'd2047));
		push_frame(make_frame(32'd30000, 8'h00, 12'd2252, 12'd1844));
		push_frame(make_frame(32'd50000, 8'h00, 12'd2253, 12'd1843));
		push_frame(make_frame(32'd60000, 8'hA5, 12'd2047, 12'd2049));
		push_frame(make_frame(32'hFFFF_F000, 8'hA5, 12'd4095, 12'd4095));
		push_frame(make_frame(32'h0000_1000, 8'h5A, 12'd0, 12'd0));
		push_frame(make_frame(32'h0000_6000, 8'h5A, 12'd1, 12'd4094));
		push_frame(make_frame(32'h0000_6000, 8'h5A, 12'd3000, 12'd1000));
		push_frame(make_frame(32'h0000_6001, 8'hA5, 12'd2249, 12'd1847));
		push_frame(make_frame(32'h0000_4000, 8'hA5, 12'd2050, 12'd2046));
		push_frame(make_frame(32'hFFFF_FFFF, 8'h00, 12'd3500, 12'd600));
		push_frame(make_frame(32'hFFFF_FFFF, 8'h00, 12'd2048, 12'd2048));

		for (int phase = 0; phase < SettingPhases; phase++) begin
			wait_idle();
			choose_settings(phase);
			write_settings();
			for (int n = 0; n < FramesPerPhase; n++)
				push_frame(random_frame());
		end
		wait_idle();

		if (mismatch_total == 0 && frames_in_flight == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
